[rtl/core/rfr_pkg.sv]
// Types, codes and helper functions shared by the RPC fragment reassembler.
// No dependencies; every other file in rtl/core refers to this package by scoped names.
`default_nettype none

package rfr_pkg;

    // Command codes of an input item.
    localparam logic [1:0] CMD_FRAG  = 2'd0;
    localparam logic [1:0] CMD_OPEN  = 2'd1;
    localparam logic [1:0] CMD_CLOSE = 2'd2;

    // Fragment kinds, bits 1:0 of the type byte.
    localparam logic [1:0] KIND_CONT    = 2'd0;
    localparam logic [1:0] KIND_REQUEST = 2'd1;
    localparam logic [1:0] KIND_REPLY   = 2'd2;
    localparam logic [1:0] KIND_NOTIF   = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_API_WORD  = 1'b0;
    localparam logic CFG_MAX_FRAGS = 1'b1;

    localparam logic [7:0] API_WORD_RST  = 8'd33;
    localparam logic [5:0] MAX_FRAGS_RST = 6'd62;

    // Header sizes and payload counter limit.
    localparam logic [7:0]  HDR_BYTES       = 8'd8;
    localparam logic [7:0]  REPLY_HDR_BYTES = 8'd12;
    localparam logic [13:0] SIZE_MAX        = 14'h3FFF;

    // Event codes.
    localparam logic [3:0] EV_IGNORED       = 4'd0;
    localparam logic [3:0] EV_SHORT         = 4'd1;
    localparam logic [3:0] EV_BAD_API       = 4'd2;
    localparam logic [3:0] EV_BAD_TYPE      = 4'd3;
    localparam logic [3:0] EV_REPLY_ABORT   = 4'd4;
    localparam logic [3:0] EV_NOTIF_ABORT   = 4'd5;
    localparam logic [3:0] EV_ACCEPTED      = 4'd6;
    localparam logic [3:0] EV_REPLY_DONE    = 4'd7;
    localparam logic [3:0] EV_NOTIF_DONE    = 4'd8;
    localparam logic [3:0] EV_REPLY_SETUP   = 4'd9;
    localparam logic [3:0] EV_NOTIF_SETUP   = 4'd10;
    localparam logic [3:0] EV_OPENED        = 4'd11;
    localparam logic [3:0] EV_TABLE_FULL    = 4'd12;
    localparam logic [3:0] EV_CLOSED        = 4'd13;

    // Error classes.
    localparam logic [2:0] CLS_OK      = 3'd0;
    localparam logic [2:0] CLS_UNSUP   = 3'd1;
    localparam logic [2:0] CLS_NOMEM   = 3'd2;
    localparam logic [2:0] CLS_NODEV   = 3'd3;
    localparam logic [2:0] CLS_DENIED  = 3'd4;
    localparam logic [2:0] CLS_BUSY    = 3'd5;
    localparam logic [2:0] CLS_INVALID = 3'd6;
    localparam logic [2:0] CLS_BADMSG  = 3'd7;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  frag_len;
        logic [7:0]  hdr_api;
        logic [7:0]  hdr_type;
        logic [15:0] seq;
        logic [31:0] msg_id;
        logic [31:0] remote_err;
    } item_t;

    typedef struct packed {
        logic [3:0]  event_res;
        logic [15:0] out_seq;
        logic [31:0] out_msg_id;
        logic [13:0] total_size;
        logic [2:0]  err_class;
    } result_t;

    typedef struct packed {
        result_t res;
        logic    last;
    } fifo_entry_t;

    // Lookup answer of the open-call table for the current sequence id.
    typedef struct packed {
        logic        hit;
        logic [31:0] hit_id;
        logic        has_free;
    } tbl_lookup_t;

    // Update request to the open-call table.
    typedef struct packed {
        logic do_open;
        logic do_close;
    } tbl_op_t;

    function automatic logic [2:0] remap_error(input logic [31:0] e);
        logic [2:0] c;
        if (e == 32'd0) begin
            c = CLS_OK;
        end else if (e == 32'hFFFF_FFFF) begin
            c = CLS_UNSUP;
        end else if (e == 32'd1) begin
            c = CLS_NOMEM;
        end else if (e == 32'd2) begin
            c = CLS_NODEV;
        end else if (e == 32'd3) begin
            c = CLS_DENIED;
        end else if (e == 32'd5) begin
            c = CLS_BUSY;
        end else if (e == 32'd4 || (e >= 32'd6 && e <= 32'h11)) begin
            c = CLS_INVALID;
        end else begin
            c = CLS_BADMSG;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/core/rfr_call_table.sv]
// Table of open calls: valid bit, sequence id and message id per entry, searched by sequence id.
// Depends on rfr_pkg for the lookup and update structs.
`default_nettype none

module rfr_call_table #(
    parameter int DEPTH = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [15:0]          seq,
    input  wire logic [31:0]          msg_id,
    input  wire rfr_pkg::tbl_op_t     op,
    output rfr_pkg::tbl_lookup_t      lookup
);

    localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DEPTH-1:0] vld_reg;
    logic [15:0]      seq_reg [DEPTH];
    logic [31:0]      id_reg  [DEPTH];

    logic            hit;
    logic            has_free;
    logic [IdxW-1:0] hit_idx;
    logic [IdxW-1:0] free_idx;
    logic [IdxW-1:0] wr_idx;

    // Lowest matching entry and lowest free entry.
    always_comb begin
        hit      = 1'b0;
        has_free = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (vld_reg[i] && (seq_reg[i] == seq)) begin
                hit     = 1'b1;
                hit_idx = IdxW'(i);
            end
            if (!vld_reg[i]) begin
                has_free = 1'b1;
                free_idx = IdxW'(i);
            end
        end
    end

    assign wr_idx          = hit ? hit_idx : free_idx;
    assign lookup.hit      = hit;
    assign lookup.hit_id   = id_reg[hit_idx];
    assign lookup.has_free = has_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (op.do_open && (hit || has_free)) begin
                vld_reg[wr_idx] <= 1'b1;
            end
            if (op.do_close && hit) begin
                vld_reg[hit_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (op.do_open && (hit || has_free)) begin
            seq_reg[wr_idx] <= seq;
            id_reg[wr_idx]  <= msg_id;
        end
    end

endmodule

`default_nettype wire

[rtl/core/rfr_engine.sv]
// Per-item decision logic and the state of the one message being gathered.
// Depends on rfr_pkg; takes its table answers from rfr_call_table.
`default_nettype none

module rfr_engine #(
    parameter int MAX_MSG_BYTES = 240
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  fire,
    input  wire rfr_pkg::item_t        item,
    input  wire logic [7:0]            api_word,
    input  wire logic [5:0]            max_frags,
    input  wire rfr_pkg::tbl_lookup_t  lookup,
    output rfr_pkg::tbl_op_t           tbl_op,
    output rfr_pkg::result_t           res0,
    output rfr_pkg::result_t           res1,
    output logic                       two
);

    localparam int CmpW = $clog2(MAX_MSG_BYTES + 1) + 8;

    logic        act_vld_reg,   act_vld_next;
    logic        act_reply_reg, act_reply_next;
    logic [31:0] act_id_reg,    act_id_next;
    logic [15:0] act_seq_reg,   act_seq_next;
    logic [5:0]  exp_reg,       exp_next;
    logic [5:0]  rcv_reg,       rcv_next;
    logic [13:0] bytes_reg,     bytes_next;
    logic [2:0]  cls_reg,       cls_next;

    logic             len_big;
    logic [7:0]       len;
    logic [1:0]       kind;
    logic [5:0]       frags;
    logic [7:0]       pay_hdr;
    logic [7:0]       pay_rep;
    logic [14:0]      sum;
    logic [13:0]      sum_sat;
    logic [5:0]       rcv_inc;
    logic [2:0]       rep_cls;
    logic             have_ab;
    rfr_pkg::result_t ab;
    rfr_pkg::result_t echo;
    rfr_pkg::result_t m;

    assign len_big = {{(CmpW - 8){1'b0}}, item.frag_len} > CmpW'(MAX_MSG_BYTES);
    assign len     = len_big ? 8'(MAX_MSG_BYTES) : item.frag_len;
    assign kind    = item.hdr_type[1:0];
    assign frags   = item.hdr_type[7:2];
    assign pay_hdr = len - rfr_pkg::HDR_BYTES;
    assign pay_rep = len - rfr_pkg::REPLY_HDR_BYTES;
    assign sum     = {1'b0, bytes_reg} + {7'd0, pay_hdr};
    assign sum_sat = (sum > {1'b0, rfr_pkg::SIZE_MAX}) ? rfr_pkg::SIZE_MAX : sum[13:0];
    assign rcv_inc = rcv_reg + 6'd1;
    assign rep_cls = rfr_pkg::remap_error(item.remote_err);

    assign ab   = '{event_res: act_reply_reg ? rfr_pkg::EV_REPLY_ABORT : rfr_pkg::EV_NOTIF_ABORT,
                    out_seq: act_seq_reg, out_msg_id: act_id_reg,
                    total_size: bytes_reg, err_class: rfr_pkg::CLS_OK};
    assign echo = '{event_res: rfr_pkg::EV_IGNORED, out_seq: item.seq,
                    out_msg_id: item.msg_id, total_size: 14'd0,
                    err_class: rfr_pkg::CLS_OK};

    always_comb begin
        act_vld_next   = act_vld_reg;
        act_reply_next = act_reply_reg;
        act_id_next    = act_id_reg;
        act_seq_next   = act_seq_reg;
        exp_next       = exp_reg;
        rcv_next       = rcv_reg;
        bytes_next     = bytes_reg;
        cls_next       = cls_reg;
        have_ab        = 1'b0;
        m              = echo;
        tbl_op         = '0;

        case (item.cmd)
            rfr_pkg::CMD_OPEN: begin
                tbl_op.do_open = 1'b1;
                m.event_res = (lookup.hit || lookup.has_free) ? rfr_pkg::EV_OPENED
                                                              : rfr_pkg::EV_TABLE_FULL;
            end
            rfr_pkg::CMD_CLOSE: begin
                if (lookup.hit) begin
                    tbl_op.do_close = 1'b1;
                    m.event_res  = rfr_pkg::EV_CLOSED;
                    m.out_msg_id = lookup.hit_id;
                end
            end
            rfr_pkg::CMD_FRAG: begin
                if (len < rfr_pkg::HDR_BYTES) begin
                    m.event_res = rfr_pkg::EV_SHORT;
                end else if (item.hdr_api != api_word) begin
                    m.event_res = rfr_pkg::EV_BAD_API;
                end else if (kind == rfr_pkg::KIND_REQUEST) begin
                    m.event_res = rfr_pkg::EV_BAD_TYPE;
                end else if (kind == rfr_pkg::KIND_NOTIF) begin
                    have_ab = act_vld_reg;
                    if (frags > max_frags) begin
                        act_vld_next = 1'b0;
                        m = '{event_res: rfr_pkg::EV_NOTIF_SETUP, out_seq: 16'd0,
                              out_msg_id: item.msg_id, total_size: 14'd0,
                              err_class: rfr_pkg::CLS_INVALID};
                    end else begin
                        act_vld_next   = (frags != 6'd0);
                        act_reply_next = 1'b0;
                        act_id_next    = item.msg_id;
                        act_seq_next   = 16'd0;
                        exp_next       = frags;
                        rcv_next       = 6'd0;
                        bytes_next     = {6'd0, pay_hdr};
                        cls_next       = rfr_pkg::CLS_OK;
                        m = '{event_res: (frags == 6'd0) ? rfr_pkg::EV_NOTIF_DONE
                                                         : rfr_pkg::EV_ACCEPTED,
                              out_seq: 16'd0, out_msg_id: item.msg_id,
                              total_size: {6'd0, pay_hdr}, err_class: rfr_pkg::CLS_OK};
                    end
                end else if (kind == rfr_pkg::KIND_REPLY) begin
                    if (lookup.hit && (lookup.hit_id == item.msg_id)) begin
                        have_ab = act_vld_reg;
                        if ((len < rfr_pkg::REPLY_HDR_BYTES) || (frags > max_frags)) begin
                            act_vld_next = 1'b0;
                            m.event_res = rfr_pkg::EV_REPLY_SETUP;
                            m.err_class = rfr_pkg::CLS_NOMEM;
                        end else begin
                            act_vld_next   = (frags != 6'd0);
                            act_reply_next = 1'b1;
                            act_id_next    = item.msg_id;
                            act_seq_next   = item.seq;
                            exp_next       = frags;
                            rcv_next       = 6'd0;
                            bytes_next     = {6'd0, pay_rep};
                            cls_next       = rep_cls;
                            m.event_res  = (frags == 6'd0) ? rfr_pkg::EV_REPLY_DONE
                                                           : rfr_pkg::EV_ACCEPTED;
                            m.total_size = {6'd0, pay_rep};
                            m.err_class  = rep_cls;
                        end
                    end
                end else begin
                    // Continuation of the active message.
                    if (act_vld_reg) begin
                        if ((item.msg_id != act_id_reg) || (frags != exp_reg)) begin
                            act_vld_next = 1'b0;
                            m = ab;
                        end else begin
                            bytes_next = sum_sat;
                            rcv_next   = rcv_inc;
                            m.out_seq    = act_seq_reg;
                            m.out_msg_id = act_id_reg;
                            m.total_size = sum_sat;
                            m.err_class  = act_reply_reg ? cls_reg : rfr_pkg::CLS_OK;
                            if (rcv_inc == exp_reg) begin
                                act_vld_next = 1'b0;
                                m.event_res  = act_reply_reg ? rfr_pkg::EV_REPLY_DONE
                                                             : rfr_pkg::EV_NOTIF_DONE;
                            end else begin
                                m.event_res  = rfr_pkg::EV_ACCEPTED;
                            end
                        end
                    end
                end
            end
            default: begin
                m = echo;
            end
        endcase

        if (!fire) begin
            tbl_op = '0;
        end
    end

    assign res0 = have_ab ? ab : m;
    assign res1 = m;
    assign two  = have_ab;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_vld_reg   <= 1'b0;
            act_reply_reg <= 1'b0;
            act_id_reg    <= '0;
            act_seq_reg   <= '0;
            exp_reg       <= '0;
            rcv_reg       <= '0;
            bytes_reg     <= '0;
            cls_reg       <= '0;
        end else if (fire) begin
            act_vld_reg   <= act_vld_next;
            act_reply_reg <= act_reply_next;
            act_id_reg    <= act_id_next;
            act_seq_reg   <= act_seq_next;
            exp_reg       <= exp_next;
            rcv_reg       <= rcv_next;
            bytes_reg     <= bytes_next;
            cls_reg       <= cls_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/rfr_result_fifo.sv]
// Four-entry result queue that takes up to two results per cycle and gives one per cycle.
// Depends on rfr_pkg for the queue entry type.
`default_nettype none

module rfr_result_fifo (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push0,
    input  wire logic                  push1,
    input  wire rfr_pkg::fifo_entry_t  d0,
    input  wire rfr_pkg::fifo_entry_t  d1,
    input  wire logic                  pop,
    output rfr_pkg::fifo_entry_t       head,
    output logic                       not_empty,
    output logic                       room2
);

    rfr_pkg::fifo_entry_t mem_reg [4];
    logic [1:0] wr_reg, wr_next;
    logic [1:0] rd_reg, rd_next;
    logic [2:0] cnt_reg, cnt_next;

    assign head      = mem_reg[rd_reg];
    assign not_empty = (cnt_reg != 3'd0);
    assign room2     = (cnt_reg <= 3'd2);

    always_comb begin
        wr_next  = wr_reg + {1'b0, push0} + {1'b0, push1};
        rd_next  = rd_reg + {1'b0, pop};
        cnt_next = cnt_reg + {2'd0, push0} + {2'd0, push1} - {2'd0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push0) begin
            mem_reg[wr_reg] <= d0;
        end
        if (push1) begin
            mem_reg[wr_reg + 2'd1] <= d1;
        end
    end

endmodule

`default_nettype wire

[rtl/core/rpc_fragment_reassembler.sv]
// Top level of the RPC fragment reassembler: input register, engine, call table, result queue.
// Depends on rfr_pkg, rfr_call_table, rfr_engine and rfr_result_fifo.
`default_nettype none

// Receive side of a fragmented RPC link. Every item on the s_ channel is either a received
// fragment header, an open-call command or a close-call command, and produces one or two
// result items on the m_ channel, the final one of which carries m_last. An accepted item is
// held in an input register; once the queue has room for both of its possible results, the
// engine checks the header, looks the sequence id up in the open-call table (all entries
// compared at once), updates the state of the one message being gathered and pushes its
// results into a four-entry result queue, whose head is offered on m_. An item may be
// accepted in every cycle as long as the queue has room for two results; since the m_
// channel delivers one result per cycle while m_ready is high, an item that also aborts
// the active message leaves two results to drain where an item with a single result leaves one.
// Configuration writes are taken through cfg_wr_en/cfg_index/cfg_wdata and should only
// happen while the block is idle.
module rpc_fragment_reassembler #(
    parameter int PENDING_DEPTH = 16,
    parameter int MAX_MSG_BYTES = 240
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_wdata,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_cmd,
    input  wire logic [7:0]  s_frag_len,
    input  wire logic [7:0]  s_hdr_api,
    input  wire logic [7:0]  s_hdr_type,
    input  wire logic [15:0] s_seq,
    input  wire logic [31:0] s_msg_id,
    input  wire logic [31:0] s_remote_err,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_event_res,
    output logic [15:0]      m_out_seq,
    output logic [31:0]      m_out_msg_id,
    output logic [13:0]      m_total_size,
    output logic [2:0]       m_err_class,
    output logic             m_last
);

    logic [7:0] api_word_reg;
    logic [5:0] max_frags_reg;

    rfr_pkg::item_t       item_reg;
    logic                 in_vld_reg;
    logic                 fire;
    logic                 room2;
    logic                 not_empty;
    logic                 two;
    rfr_pkg::tbl_lookup_t lookup;
    rfr_pkg::tbl_op_t     tbl_op;
    rfr_pkg::result_t     res0;
    rfr_pkg::result_t     res1;
    rfr_pkg::fifo_entry_t d0;
    rfr_pkg::fifo_entry_t d1;
    rfr_pkg::fifo_entry_t head;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            api_word_reg  <= rfr_pkg::API_WORD_RST;
            max_frags_reg <= rfr_pkg::MAX_FRAGS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                rfr_pkg::CFG_API_WORD:  api_word_reg  <= cfg_wdata;
                rfr_pkg::CFG_MAX_FRAGS: max_frags_reg <= cfg_wdata[5:0];
                default: begin
                end
            endcase
        end
    end

    // The held item is processed once the queue can take both of its possible results.
    assign fire    = in_vld_reg && room2;
    assign s_ready = !in_vld_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= '{cmd: s_cmd, frag_len: s_frag_len, hdr_api: s_hdr_api,
                          hdr_type: s_hdr_type, seq: s_seq, msg_id: s_msg_id,
                          remote_err: s_remote_err};
        end
    end

    rfr_call_table #(
        .DEPTH (PENDING_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .seq     (item_reg.seq),
        .msg_id  (item_reg.msg_id),
        .op      (tbl_op),
        .lookup  (lookup)
    );

    rfr_engine #(
        .MAX_MSG_BYTES (MAX_MSG_BYTES)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .item      (item_reg),
        .api_word  (api_word_reg),
        .max_frags (max_frags_reg),
        .lookup    (lookup),
        .tbl_op    (tbl_op),
        .res0      (res0),
        .res1      (res1),
        .two       (two)
    );

    // When an abort precedes the main result, only the second result closes the item.
    assign d0 = '{res: res0, last: !two};
    assign d1 = '{res: res1, last: 1'b1};

    rfr_result_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push0     (fire),
        .push1     (fire && two),
        .d0        (d0),
        .d1        (d1),
        .pop       (m_valid && m_ready),
        .head      (head),
        .not_empty (not_empty),
        .room2     (room2)
    );

    assign m_valid      = not_empty;
    assign m_event_res  = head.res.event_res;
    assign m_out_seq    = head.res.out_seq;
    assign m_out_msg_id = head.res.out_msg_id;
    assign m_total_size = head.res.total_size;
    assign m_err_class  = head.res.err_class;
    assign m_last       = head.last;

endmodule

`default_nettype wire
